@@ rtl/core/lbbc_pkg.sv @@
// Package for the LRU block buffer cache: slot counts, result kinds, modes
// and the sequencer state type. No dependencies.
package lbbc_pkg;
   localparam int NumSlotsDefault = 16;
   localparam int ModeW = 3;
   localparam int UnitW = 5;
   localparam int BlockW = 32;
   localparam int SlotW = 4;
   localparam int KindW = 2;
   localparam int CsrW = 5;

   localparam logic [ModeW-1:0] MODE_GET_READ   = 3'd0;
   localparam logic [ModeW-1:0] MODE_GET_NOREAD = 3'd1;
   localparam logic [ModeW-1:0] MODE_MARK_DIRTY = 3'd2;
   localparam logic [ModeW-1:0] MODE_INVAL_UNIT = 3'd3;
   localparam logic [ModeW-1:0] MODE_FLUSH_UNIT = 3'd4;
   localparam logic [ModeW-1:0] MODE_FLUSH_ALL  = 3'd5;

   localparam logic [KindW-1:0] KIND_GRANT = 2'd0;
   localparam logic [KindW-1:0] KIND_WB    = 2'd1;
   localparam logic [KindW-1:0] KIND_READ  = 2'd2;
   localparam logic [KindW-1:0] KIND_DONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_MISS_WB, ST_MISS_RD, ST_GRANT, ST_WALK, ST_DONE
   } state_type;
endpackage

@@ rtl/core/lru_block_buffer_cache.sv @@
// LRU block buffer cache. A get compares all active slots at once; a hit
// goes to the grant, a miss first writes back a dirty victim and, for a read,
// issues a read; the position/tag state lives in a chain of cells, and a
// move-to-front is one shift of the chain up to the chosen position. Flushes
// walk the active positions one a cycle unless a waiting response stalls them.
// Writing csr re-initializes all slots; dirty data is dropped.
module lru_block_buffer_cache import lbbc_pkg::*; #(
   parameter int NUM_SLOTS = NumSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ModeW-1:0]  req_mode,
   input  logic [UnitW-1:0]  req_unit,
   input  logic [BlockW-1:0] req_block_number,
   input  logic [SlotW-1:0]  req_slot,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KindW-1:0]  rsp_kind,
   output logic [SlotW-1:0]  rsp_slot_res,
   output logic [UnitW-1:0]  rsp_unit_res,
   output logic [BlockW-1:0] rsp_block_number_res,
   output logic              rsp_hit,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [CsrW-1:0]   csr_wdata
);
   localparam int IdxW = $clog2(NUM_SLOTS);
   localparam int CntW = $clog2(NUM_SLOTS + 1);

   logic [IdxW-1:0]   c_slot  [NUM_SLOTS];
   logic [UnitW-1:0]  c_unit  [NUM_SLOTS];
   logic [BlockW-1:0] c_block [NUM_SLOTS];
   logic              c_valid [NUM_SLOTS];
   logic              c_dirty [NUM_SLOTS];
   logic              shift   [NUM_SLOTS];
   logic              set_d   [NUM_SLOTS];
   logic              clr_d   [NUM_SLOTS];
   logic              clr_v   [NUM_SLOTS];

   state_type state_ff, state_in;
   logic [CntW-1:0]   n_ff, n_in;
   logic [ModeW-1:0]  mode_ff, mode_in;
   logic [UnitW-1:0]  unit_ff, unit_in;
   logic [BlockW-1:0] blk_ff, blk_in;
   logic [SlotW-1:0]  sl_ff, sl_in;
   logic [IdxW-1:0]   pos_ff, pos_in;
   logic              hq_ff, hq_in;
   logic              init_r;
   logic [CntW-1:0]   csr_sat;

   // front position after a move carries the fill
   logic              ld_front;
   logic [IdxW-1:0]   shift_to;
   logic              do_shift;

   logic              ov_ff, ov_in;
   logic [KindW-1:0]  ok_ff, ok_in;
   logic [SlotW-1:0]  os_ff, os_in;
   logic [UnitW-1:0]  ou_ff, ou_in;
   logic [BlockW-1:0] ob_ff, ob_in;
   logic              oh_ff, oh_in, ol_ff, ol_in;

   logic              hit_any;
   logic [IdxW-1:0]   hit_pos;

   always_comb begin
      csr_sat = (csr_wdata == '0) ? CntW'(1) :
                (32'(csr_wdata) > 32'(NUM_SLOTS)) ? CntW'(NUM_SLOTS) : CntW'(csr_wdata);
   end

   assign init_r = reset || csr_we;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      logic [IdxW-1:0]   p_slot;
      logic [UnitW-1:0]  p_unit;
      logic [BlockW-1:0] p_block;
      logic              p_valid, p_dirty;
      if (i == 0) begin : g_front
         // position 0 takes the slot moved to the front
         assign p_slot  = c_slot[shift_to];
         assign p_unit  = ld_front ? unit_ff : c_unit[shift_to];
         assign p_block = ld_front ? blk_ff : c_block[shift_to];
         assign p_valid = ld_front ? 1'b1 : c_valid[shift_to];
         assign p_dirty = ld_front ? 1'b0 : c_dirty[shift_to];
      end else begin : g_rest
         assign p_slot  = c_slot[i-1];
         assign p_unit  = c_unit[i-1];
         assign p_block = c_block[i-1];
         assign p_valid = c_valid[i-1];
         assign p_dirty = c_dirty[i-1];
      end
      assign shift[i] = do_shift && (IdxW'(i) <= shift_to);
      lbbc_cell #(.SlotIdxW(IdxW)) u_cell (
         .clock, .init(init_r), .init_slot(IdxW'(i)), .shift(shift[i]),
         .prev_slot(p_slot), .prev_unit(p_unit), .prev_block(p_block),
         .prev_valid(p_valid), .prev_dirty(p_dirty),
         .set_dirty(set_d[i]), .clr_dirty(clr_d[i]), .clr_valid(clr_v[i]),
         .slot(c_slot[i]), .unit(c_unit[i]), .block(c_block[i]),
         .valid(c_valid[i]), .dirty(c_dirty[i]));
   end

   always_comb begin
      hit_any = 1'b0;
      hit_pos = '0;
      for (int i = NUM_SLOTS-1; i >= 0; i--) begin
         if ((CntW'(i) < n_ff) && c_valid[i] && c_unit[i] == unit_ff &&
             c_block[i] == blk_ff) begin
            hit_any = 1'b1;
            hit_pos = IdxW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; mode_in = mode_ff; unit_in = unit_ff; blk_in = blk_ff;
      sl_in = sl_ff; pos_in = pos_ff; hq_in = hq_ff;
      ov_in = ov_ff; ok_in = ok_ff; os_in = os_ff; ou_in = ou_ff;
      ob_in = ob_ff; oh_in = oh_ff; ol_in = ol_ff;
      req_ready = 1'b0;
      do_shift = 1'b0; ld_front = 1'b0; shift_to = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         set_d[i] = 1'b0; clr_d[i] = 1'b0; clr_v[i] = 1'b0;
      end
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in = req_mode; unit_in = req_unit; blk_in = req_block_number;
               sl_in = req_slot; pos_in = '0;
               if (req_mode == MODE_GET_READ || req_mode == MODE_GET_NOREAD)
                  state_in = ST_SEARCH;
               else if (req_mode == MODE_FLUSH_UNIT || req_mode == MODE_FLUSH_ALL ||
                        req_mode == MODE_INVAL_UNIT)
                  state_in = ST_WALK;
               else if (req_mode == MODE_MARK_DIRTY)
                  state_in = ST_DONE;
            end
         end
         ST_SEARCH: begin
            do_shift = 1'b1;
            // hit flag is held aside so a waiting beat keeps its payload
            if (hit_any) begin
               shift_to = hit_pos;
               state_in = ST_GRANT;
               hq_in = 1'b1;
            end else begin
               shift_to = IdxW'(n_ff - CntW'(1));
               hq_in = 1'b0;
               state_in = ST_MISS_WB;
            end
         end
         ST_MISS_WB: begin
            // front now holds the victim, still with its old tag
            if (!ov_ff || rsp_ready) begin
               if (c_valid[0] && c_dirty[0]) begin
                  ov_in = 1'b1; ok_in = KIND_WB; os_in = SlotW'(c_slot[0]);
                  ou_in = c_unit[0]; ob_in = c_block[0]; oh_in = 1'b0; ol_in = 1'b0;
               end
               if (mode_ff == MODE_GET_READ) state_in = ST_MISS_RD;
               else state_in = ST_GRANT;
               // retag the front slot in place
               do_shift = 1'b1; ld_front = 1'b1; shift_to = '0;
            end
         end
         ST_MISS_RD: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1; ok_in = KIND_READ; os_in = SlotW'(c_slot[0]);
               ou_in = unit_ff; ob_in = blk_ff; oh_in = 1'b0; ol_in = 1'b0;
               state_in = ST_GRANT;
            end
         end
         ST_GRANT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1; ok_in = KIND_GRANT; os_in = SlotW'(c_slot[0]);
               ou_in = unit_ff; ob_in = blk_ff; oh_in = hq_ff; ol_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (CntW'(pos_ff) >= n_ff) begin
               state_in = ST_DONE;
            end else if (mode_ff == MODE_INVAL_UNIT) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if ((CntW'(i) < n_ff) && c_unit[i] == unit_ff) begin
                     clr_v[i] = 1'b1; clr_d[i] = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end else if (!ov_ff || rsp_ready) begin
               if (mode_ff == MODE_FLUSH_ALL || c_unit[pos_ff] == unit_ff) begin
                  if (c_valid[pos_ff] && c_dirty[pos_ff]) begin
                     ov_in = 1'b1; ok_in = KIND_WB; os_in = SlotW'(c_slot[pos_ff]);
                     ou_in = c_unit[pos_ff]; ob_in = c_block[pos_ff];
                     oh_in = 1'b0; ol_in = 1'b0;
                  end
                  clr_d[pos_ff] = 1'b1;
                  if (mode_ff == MODE_FLUSH_ALL) clr_v[pos_ff] = 1'b1;
               end
               if (CntW'(pos_ff) == n_ff - CntW'(1)) state_in = ST_DONE;
               else pos_in = pos_ff + IdxW'(1);
            end
         end
         ST_DONE: begin
            if (!ov_ff || rsp_ready) begin
               if (mode_ff == MODE_MARK_DIRTY) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if ((CntW'(i) < n_ff) && (32'(sl_ff) < 32'(n_ff)) &&
                         (32'(c_slot[i]) == 32'(sl_ff)))
                        set_d[i] = 1'b1;
                  end
               end
               ov_in = 1'b1; ok_in = KIND_DONE; os_in = '0; ou_in = '0; ob_in = '0;
               oh_in = 1'b0; ol_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) n_in = csr_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= CntW'(NUM_SLOTS);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         ov_ff    <= ov_in;
      end
      mode_ff <= mode_in; unit_ff <= unit_in; blk_ff <= blk_in;
      sl_ff <= sl_in; pos_ff <= pos_in; hq_ff <= hq_in;
      ok_ff <= ok_in; os_ff <= os_in; ou_ff <= ou_in; ob_ff <= ob_in;
      oh_ff <= oh_in; ol_ff <= ol_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = ok_ff;
   assign rsp_slot_res = os_ff;
   assign rsp_unit_res = ou_ff;
   assign rsp_block_number_res = ob_ff;
   assign rsp_hit = oh_ff;
   assign rsp_last = ol_ff;
endmodule

@@ rtl/core/lbbc_cell.sv @@
// One slot of the recency chain: tag, valid and dirty of the slot held at
// this position. Shifts from its front neighbor on a move-to-front.
// Depends on lbbc_pkg.
module lbbc_cell import lbbc_pkg::*; #(
   parameter int SlotIdxW = 4
) (
   input  logic                clock,
   input  logic                init,
   input  logic [SlotIdxW-1:0] init_slot,
   input  logic                shift,
   input  logic [SlotIdxW-1:0] prev_slot,
   input  logic [UnitW-1:0]    prev_unit,
   input  logic [BlockW-1:0]   prev_block,
   input  logic                prev_valid,
   input  logic                prev_dirty,
   input  logic                set_dirty,
   input  logic                clr_dirty,
   input  logic                clr_valid,
   output logic [SlotIdxW-1:0] slot,
   output logic [UnitW-1:0]    unit,
   output logic [BlockW-1:0]   block,
   output logic                valid,
   output logic                dirty
);
   logic [SlotIdxW-1:0] slot_ff, slot_in;
   logic [UnitW-1:0]    unit_ff, unit_in;
   logic [BlockW-1:0]   block_ff, block_in;
   logic                valid_ff, valid_in, dirty_ff, dirty_in;

   always_comb begin
      slot_in  = slot_ff;
      unit_in  = unit_ff;
      block_in = block_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      if (init) begin
         slot_in  = init_slot;
         unit_in  = '0;
         block_in = '0;
         valid_in = 1'b0;
         dirty_in = 1'b0;
      end else if (shift) begin
         slot_in  = prev_slot;
         unit_in  = prev_unit;
         block_in = prev_block;
         valid_in = prev_valid;
         dirty_in = prev_dirty;
      end else begin
         if (set_dirty) dirty_in = 1'b1;
         if (clr_dirty) dirty_in = 1'b0;
         if (clr_valid) valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      unit_ff  <= unit_in;
      block_ff <= block_in;
      valid_ff <= valid_in;
      dirty_ff <= dirty_in;
   end

   assign slot  = slot_ff;
   assign unit  = unit_ff;
   assign block = block_ff;
   assign valid = valid_ff;
   assign dirty = dirty_ff;
endmodule
